// File: hw/rtl/bcdep_pkg.sv
// ----------------------------------------------------------------------------
// bcdep_pkg
// Shared types, constants and helper functions for the BCD clock register
// to epoch seconds converter.
// ----------------------------------------------------------------------------
package bcdep_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HALTED = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned DAYS_PER_YEAR = 365;
    // Years from the epoch year to the start of the century
    localparam int unsigned YEAR_OFFSET   = 2000 - 1970;

    localparam int DAYS_W = 16;
    localparam int SOD_W  = 19;
    localparam int EPOCH_W = 32;

    // One register image as it arrives
    typedef struct packed {
        logic [7:0] year_byte;
        logic [7:0] month_byte;
        logic [7:0] date_byte;
        logic [7:0] hours_byte;
        logic [7:0] minutes_byte;
        logic [7:0] seconds_byte;
    } t_regs;

    // Decoded image: status, (days - 1) since epoch, seconds of day
    typedef struct packed {
        logic [1:0]        status;
        logic [DAYS_W-1:0] days_m1;
        logic [SOD_W-1:0]  sod;
    } t_decoded;

    // Packed BCD byte to binary (0..165 for any pattern, 8 bits)
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0, b[3:0]};
    endfunction

    // True when both nibbles are decimal digits
    function automatic logic bcd_valid(input logic [7:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    // Days in the year before the first of month 1..12
    function automatic logic [8:0] cum_days(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hw/rtl/bcdep_decode.sv
// ----------------------------------------------------------------------------
// bcdep_decode
// Checks and decodes one BCD register image into a status, the day count
// before the given day and the seconds within that day.
// ----------------------------------------------------------------------------
module bcdep_decode (
    input  bcdep_pkg::t_regs    i_regs,
    output bcdep_pkg::t_decoded o_dec
);
    import bcdep_pkg::*;

    logic [7:0]        w_sec_raw;
    logic [7:0]        w_hr12_raw;
    logic [7:0]        w_sec;
    logic [7:0]        w_min;
    logic [7:0]        w_day;
    logic [7:0]        w_mon;
    logic [7:0]        w_yr;
    logic [7:0]        w_hr24_bin;
    logic [7:0]        w_hr12_bin;
    logic [7:0]        w_hr;
    logic              w_is12;
    logic              w_hr_ok;
    logic              w_digits_ok;
    logic              w_mon_ok;
    logic [7:0]        w_yr_off;
    logic [DAYS_W-1:0] w_days_m1;
    logic              w_leap_add;
    logic [SOD_W-1:0]  w_sod;

    // Decode digits
    assign w_sec_raw  = {1'b0, i_regs.seconds_byte[6:0]};
    assign w_hr12_raw = {3'b0, i_regs.hours_byte[4:0]};
    assign w_sec      = bcd_to_bin(w_sec_raw);
    assign w_min      = bcd_to_bin(i_regs.minutes_byte);
    assign w_day      = bcd_to_bin(i_regs.date_byte);
    assign w_mon      = bcd_to_bin(i_regs.month_byte);
    assign w_yr       = bcd_to_bin(i_regs.year_byte);
    assign w_hr24_bin = bcd_to_bin(i_regs.hours_byte);
    assign w_hr12_bin = bcd_to_bin(w_hr12_raw);
    assign w_is12     = i_regs.hours_byte[6];

    // Convert twelve-hour form: 12 AM is midnight, PM adds 12 except at noon
    always_comb begin
        if (!w_is12) begin
            w_hr    = w_hr24_bin;
            w_hr_ok = bcd_valid(i_regs.hours_byte);
        end else begin
            w_hr_ok = bcd_valid(w_hr12_raw);
            if (i_regs.hours_byte[5]) begin
                w_hr = (w_hr12_bin == 8'd12) ? w_hr12_bin : w_hr12_bin + 8'd12;
            end else begin
                w_hr = (w_hr12_bin == 8'd12) ? 8'd0 : w_hr12_bin;
            end
        end
    end

    assign w_digits_ok = bcd_valid(w_sec_raw) && bcd_valid(i_regs.minutes_byte)
                      && w_hr_ok && bcd_valid(i_regs.date_byte)
                      && bcd_valid(i_regs.month_byte) && bcd_valid(i_regs.year_byte);
    assign w_mon_ok    = (w_mon >= 8'd1) && (w_mon <= 8'd12);

    // Count days: whole years, leap days before the year, months, date
    assign w_yr_off   = w_yr + 8'(YEAR_OFFSET);
    assign w_leap_add = (w_yr[1:0] == 2'b00) && (w_mon >= 8'd3);
    assign w_days_m1  = DAYS_W'(w_yr_off * DAYS_W'(DAYS_PER_YEAR))
                      + DAYS_W'((w_yr_off + 8'd1) >> 2)
                      + DAYS_W'(cum_days(w_mon[3:0]))
                      + DAYS_W'(w_day)
                      + DAYS_W'(w_leap_add)
                      - DAYS_W'(1);

    // Seconds within the day, out-of-range fields added as they are
    assign w_sod = SOD_W'(w_sec) + SOD_W'(w_min * SOD_W'(60))
                 + SOD_W'(w_hr * SOD_W'(3600));

    // Pick status: halt wins over any digit check
    always_comb begin
        o_dec.days_m1 = w_days_m1;
        o_dec.sod     = w_sod;
        if (i_regs.seconds_byte[7]) begin
            o_dec.status = ST_HALTED;
        end else if (!w_digits_ok || !w_mon_ok) begin
            o_dec.status = ST_BAD;
        end else begin
            o_dec.status = ST_OK;
        end
    end

endmodule

// File: hw/rtl/bcd_clock_registers_to_epoch_unit.sv
// ----------------------------------------------------------------------------
// bcd_clock_registers_to_epoch_unit
// Converts a BCD real-time-clock register image to Unix epoch seconds.
// ----------------------------------------------------------------------------
// One register image (seconds, minutes, hours, date, month, year in packed
// BCD, years 2000..2099, hours in 12- or 24-hour form) is taken per item and
// gives one result: seconds since 1970-01-01 00:00:00 and a status (0 ok,
// 1 clock halted, 2 bad BCD digit or month; epoch is 0 unless ok). The unit
// accepts one item every clock cycle while the output is not stalled and
// presents its result through three registers: an input register, a
// decode stage that counts days and seconds of day, and an output register
// fed by the single days-by-86400 multiply. Back pressure on the output
// stalls the stages behind it.
module bcd_clock_registers_to_epoch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seconds_byte, minutes_byte, hours_byte, date_byte, month_byte, year_byte
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // epoch_seconds
    output logic [31:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);
    import bcdep_pkg::*;

    logic                r_v1;
    t_regs               r_img;
    logic                r_v2;
    t_decoded            r_dec;
    logic                r_v3;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [1:0]          r_status;
    t_decoded            w_dec;
    logic                w_rdy2;
    logic                w_rdy3;
    logic [EPOCH_W-1:0]  n_epoch;

    // Stall chain: a stage loads when empty or when its contents move on
    assign w_rdy3        = !r_v3 || m_axis_tready;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign s_axis_tready = !r_v1 || w_rdy2;

    bcdep_decode u_decode (
        .i_regs (r_img),
        .o_dec  (w_dec)
    );

    // Scale days to seconds and add seconds of day; zero when not ok
    assign n_epoch = (r_dec.status == ST_OK)
                   ? EPOCH_W'(r_dec.days_m1) * EPOCH_W'(SECS_PER_DAY) + EPOCH_W'(r_dec.sod)
                   : '0;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s_axis_tready) r_v1 <= s_axis_tvalid;
            if (w_rdy2)        r_v2 <= r_v1;
            if (w_rdy3)        r_v3 <= r_v2;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) r_img <= t_regs'(s_axis_tdata);
        if (w_rdy2)        r_dec <= w_dec;
        if (w_rdy3) begin
            r_epoch  <= n_epoch;
            r_status <= r_dec.status;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_epoch;
    assign m_axis_tuser  = r_status;

    // A non-ok result never carries a time
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("epoch nonzero with error status");

    // Status is always one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_HALTED
                           || m_axis_tuser == ST_BAD))
        else $error("undefined status code");

    // A decoded item moving on reaches the output register
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3) |=> r_v3)
        else $error("item lost between decode and output");

    // A stalled decode stage holds its item
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !w_rdy2) |=> (r_v2 && $stable(r_dec)))
        else $error("decode stage changed while stalled");

endmodule

// File: dv/tb_bcd_clock_registers_to_epoch_unit.sv
// ----------------------------------------------------------------------------
// tb_bcd_clock_registers_to_epoch_unit
// Self-checking bench for the BCD clock register to epoch seconds converter.
// ----------------------------------------------------------------------------
// Every register image accepted on the input stream is converted by a local
// calendar predictor and queued. Each item leaving the output stream is
// checked against the oldest queued result, epoch seconds and status both.
// Directed images cover field extremes, halted clock, bad digits, month
// range, twelve-hour conversion, leap days and date zero. Random images are
// mostly well-formed with random content plus halted, broken and raw noise
// images. Both sides idle in random bursts, the receiver holds off for a
// long stretch once, and the last part runs at full rate.
// ----------------------------------------------------------------------------
module tb_bcd_clock_registers_to_epoch_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdep_pkg::*;

    localparam int unsigned DAY_SECS      = 86400;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned LONG_HOLD     = 300;

    typedef struct packed {
        logic [31:0] epoch;
        logic [1:0]  status;
    } t_epoch_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // seconds_byte, minutes_byte, hours_byte, date_byte, month_byte, year_byte
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // epoch_seconds
    logic [31:0] m_axis_tdata;
    // status
    logic [1:0]  m_axis_tuser;

    t_epoch_result expected_epochs[$];
    int unsigned   mismatch_count = 0;
    bit            tx_idle_en = 1'b1;
    bit            rx_idle_en = 1'b1;
    bit            rx_hold_req = 1'b0;

    bcd_clock_registers_to_epoch_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    function automatic bit digits_ok(input logic [7:0] b);
        return (b[7:4] < 4'd10) && (b[3:0] < 4'd10);
    endfunction

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic int unsigned days_before_month(input int unsigned mon);
        int unsigned d;
        case (mon)
            1:       d = 0;
            2:       d = 31;
            3:       d = 59;
            4:       d = 90;
            5:       d = 120;
            6:       d = 151;
            7:       d = 181;
            8:       d = 212;
            9:       d = 243;
            10:      d = 273;
            11:      d = 304;
            default: d = 334;
        endcase
        return d;
    endfunction

    function automatic t_epoch_result predict_epoch(input t_regs r);
        t_epoch_result     res;
        logic [7:0]        hr_field;
        bit                ok;
        int unsigned       sec, min, hr, day, mon, year, days;
        longint unsigned   total;
        res.epoch  = '0;
        res.status = ST_OK;
        // Halted clock wins over every other check
        if (r.seconds_byte[7]) begin
            res.status = ST_HALTED;
            return res;
        end
        hr_field = r.hours_byte[6] ? {3'b000, r.hours_byte[4:0]} : r.hours_byte;
        ok = digits_ok({1'b0, r.seconds_byte[6:0]}) && digits_ok(r.minutes_byte)
            && digits_ok(hr_field) && digits_ok(r.date_byte)
            && digits_ok(r.month_byte) && digits_ok(r.year_byte);
        mon = bcd_value(r.month_byte);
        if (!ok || mon < 1 || mon > 12) begin
            res.status = ST_BAD;
            return res;
        end
        sec = bcd_value({1'b0, r.seconds_byte[6:0]});
        min = bcd_value(r.minutes_byte);
        day = bcd_value(r.date_byte);
        hr  = bcd_value(hr_field);
        // Twelve-hour form: 12 AM is midnight, 12 PM is noon
        if (r.hours_byte[6]) begin
            if (r.hours_byte[5]) begin
                if (hr != 12) hr = hr + 12;
            end else if (hr == 12) begin
                hr = 0;
            end
        end
        year = 2000 + bcd_value(r.year_byte);
        days = (year - 1970) * 365 + (year - 1969) / 4 + days_before_month(mon) + day;
        if ((year % 4) == 0 && mon >= 3) days = days + 1;
        total = longint'(days) * DAY_SECS - DAY_SECS + sec + min * 60 + hr * 3600;
        res.epoch = total[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Image builders
    // ------------------------------------------------------------------------

    function automatic logic [7:0] to_bcd(input int unsigned v);
        logic [3:0] tens, ones;
        tens = 4'(v / 10);
        ones = 4'(v % 10);
        return {tens, ones};
    endfunction

    function automatic t_regs make_image(input logic [7:0] sec, input logic [7:0] min,
                                         input logic [7:0] hr, input logic [7:0] date,
                                         input logic [7:0] mon, input logic [7:0] yr);
        t_regs r;
        r.seconds_byte = sec;
        r.minutes_byte = min;
        r.hours_byte   = hr;
        r.date_byte    = date;
        r.month_byte   = mon;
        r.year_byte    = yr;
        return r;
    endfunction

    // Well-formed image; seconds, minutes, hours and date now and then leave their calendar range
    function automatic t_regs random_clean_image();
        t_regs      r;
        logic [7:0] hr12;
        bit         wild;
        wild = ($urandom_range(0, 7) == 0);
        r.seconds_byte = wild ? {1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 9))}
                              : to_bcd($urandom_range(0, 59));
        wild = ($urandom_range(0, 7) == 0);
        r.minutes_byte = to_bcd(wild ? $urandom_range(0, 99) : $urandom_range(0, 59));
        wild = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 1) == 0) begin
            r.hours_byte = to_bcd(wild ? $urandom_range(0, 99) : $urandom_range(0, 23));
        end else begin
            hr12 = to_bcd(wild ? $urandom_range(0, 19) : $urandom_range(1, 12));
            r.hours_byte = {1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)),
                            hr12[4:0]};
        end
        wild = ($urandom_range(0, 7) == 0);
        r.date_byte  = to_bcd(wild ? $urandom_range(0, 99) : $urandom_range(1, 31));
        r.month_byte = to_bcd($urandom_range(1, 12));
        r.year_byte  = to_bcd($urandom_range(0, 99));
        return r;
    endfunction

    function automatic t_regs random_image();
        t_regs r;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        r = random_clean_image();
        case (pick)
            0, 1: begin
                // halted clock with arbitrary rest
                r = t_regs'({$urandom(), 16'($urandom())});
                r.seconds_byte[7] = 1'b1;
            end
            2, 3: begin
                r = t_regs'({$urandom(), 16'($urandom())});
            end
            4: begin
                // corrupt one nibble or push the month out of range
                case ($urandom_range(0, 6))
                    0: r.seconds_byte[3:0] = 4'($urandom_range(10, 15));
                    1: r.minutes_byte[7:4] = 4'($urandom_range(10, 15));
                    2: r.hours_byte[3:0]   = 4'($urandom_range(10, 15));
                    3: r.date_byte[7:4]    = 4'($urandom_range(10, 15));
                    4: r.year_byte[3:0]    = 4'($urandom_range(10, 15));
                    5: r.month_byte        = 8'h00;
                    default: r.month_byte  = to_bcd($urandom_range(13, 99));
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one image and hold it until accepted, then maybe pause
    task automatic send_image(input t_regs r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready bursts, idle bursts, and the requested long hold
    // ------------------------------------------------------------------------
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard: queue predictions on input, compare on output
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_epoch_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_epochs.push_back(predict_epoch(t_regs'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_epochs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected item epoch=%0d status=%0d",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_epochs.pop_front();
                    if (want.epoch !== m_axis_tdata || want.status !== m_axis_tuser) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch epoch exp=%0d got=%0d status exp=%0d got=%0d",
                                     $realtime, want.epoch, m_axis_tdata,
                                     want.status, m_axis_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: stop when nothing moves on either side for too long
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed();
        // calendar extremes
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
        send_image(make_image(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
        send_image(make_image(8'h79, 8'h99, 8'h99, 8'h99, 8'h12, 8'h99));
        // halted clock ignores the rest of the image
        send_image(make_image(8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_image(make_image(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // a bad digit in each byte
        send_image(make_image(8'h0A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
        send_image(make_image(8'h00, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h00));
        send_image(make_image(8'h00, 8'h00, 8'h3A, 8'h01, 8'h01, 8'h00));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'hF0, 8'h01, 8'h00));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h1A, 8'h00));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9F));
        // month out of range
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h10));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h10));
        // twelve-hour form: 12 AM, 12 PM, 1 AM, 11 PM, 0 PM, high bit set, bad digit
        send_image(make_image(8'h30, 8'h15, 8'h52, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'h72, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'h41, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'h71, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'h60, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'hD9, 8'h15, 8'h06, 8'h23));
        send_image(make_image(8'h30, 8'h15, 8'h4F, 8'h15, 8'h06, 8'h23));
        // leap days around February
        send_image(make_image(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h24));
        send_image(make_image(8'h00, 8'h00, 8'h12, 8'h01, 8'h03, 8'h24));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01));
        // date zero is the day before the first
        send_image(make_image(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h50));
    endtask

    task automatic test_random_images(input int unsigned count);
        repeat (count) send_image(random_image());
    endtask

    // Receiver stalls long while the sender keeps offering back to back
    task automatic test_output_backpressure(input int unsigned count);
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (count) send_image(random_image());
        tx_idle_en  = 1'b1;
    endtask

    task automatic test_full_rate(input int unsigned count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_image(random_image());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_images(1100);
        test_output_backpressure(60);
        test_random_images(100);
        test_full_rate(165);

        // drain what is still in flight
        s_axis_tvalid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
